/* sv/aging_page_replacement_macros.svh */
// assertion macros shared by the aging page replacement modules
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef AGING_PAGE_REPLACEMENT_MACROS_SVH
`define AGING_PAGE_REPLACEMENT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define APR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("apr assertion failed");

// condition must never be seen at a rising clock edge outside reset
`define APR_NEVER(lbl, cond) \
  `APR_ASSERT(lbl, !(cond))

`endif

/* sv/apr_pkg.sv */
// shared types and constants for the aging page replacement block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package apr_pkg;

  localparam int unsigned FRAMES   = 64;
  localparam int unsigned FRAME_W  = 6;
  localparam int unsigned CNT_W    = FRAME_W + 1;
  localparam int unsigned HIST_W   = 8;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W    = 16;

  localparam logic [HIST_W-1:0]   HIST_NEW   = 8'h80;
  localparam logic [HIST_W-1:0]   HIST_MAX   = 8'hFF;
  localparam logic [HIST_W:0]     BEST_INIT  = {1'b0, HIST_MAX} + 9'd1;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd100;
  localparam logic [FRAME_W-1:0]  LAST_FRAME = FRAME_W'(FRAMES - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 3'd0,
    OP_REGISTER   = 3'd1,
    OP_UNREGISTER = 3'd2,
    OP_ACCESS     = 3'd3,
    OP_VICTIM     = 3'd4
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic scan_start;
    logic scan;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_scan;
    logic scan_done;
  } status_t;

endpackage

`default_nettype wire

/* sv/apr_ctrl.sv */
// controller state machine for the aging page replacement block
// depends on apr_pkg and aging_page_replacement_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "aging_page_replacement_macros.svh"

module apr_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire apr_pkg::status_t status_i,
  output apr_pkg::cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && (state_q == ST_IDLE);

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.accept     = accept;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (status_i.needs_scan) begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `APR_ASSERT(a_accept_to_exec, accept |=> (state_q == ST_EXEC))
  `APR_ASSERT(a_scan_then_finish, (state_q == ST_SCAN && status_i.scan_done) |=> cmd_o.finish)

endmodule

`default_nettype wire

/* sv/apr_dp.sv */
// datapath for the aging page replacement block: frame flags, history memory,
// tick counter, scan counter and victim search; depends on apr_pkg and the macros header
`timescale 1ns / 1ps
`default_nettype none

`include "aging_page_replacement_macros.svh"

module apr_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire apr_pkg::cmd_t                     cmd_i,
  output apr_pkg::status_t                       status_o,
  input  wire logic [apr_pkg::OP_W-1:0]          operation_i,
  input  wire logic [apr_pkg::FRAME_W-1:0]       frame_i,
  input  wire logic                              swappable_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [apr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [apr_pkg::CFG_W-1:0]         cfg_wdata_i,
  output logic                                   result_valid_o,
  output logic                                   victim_found_o,
  output logic [apr_pkg::FRAME_W-1:0]            victim_frame_o,
  output logic                                   aged_o
);

  // latched word
  logic [apr_pkg::OP_W-1:0]    op_q;
  logic [apr_pkg::FRAME_W-1:0] frame_q;
  logic                        sw_q;

  // configuration and tick count
  logic [apr_pkg::PERIOD_W-1:0] period_q;
  logic                         enable_q;
  logic [apr_pkg::PERIOD_W-1:0] count_q;
  logic [apr_pkg::PERIOD_W:0]   count_next;
  logic                         reach;

  // per-frame flags
  logic [apr_pkg::FRAMES-1:0] valid_q;
  logic [apr_pkg::FRAMES-1:0] evict_q;
  logic [apr_pkg::FRAMES-1:0] ref_q;

  // history memory
  logic [apr_pkg::HIST_W-1:0]  hist_mem [apr_pkg::FRAMES];
  logic [apr_pkg::HIST_W-1:0]  rdata_q;
  logic                        mem_we;
  logic [apr_pkg::FRAME_W-1:0] mem_waddr;
  logic [apr_pkg::HIST_W-1:0]  mem_wdata;

  // scan
  logic [apr_pkg::CNT_W-1:0]   cnt_q;
  logic                        pipe_vld_q;
  logic [apr_pkg::FRAME_W-1:0] p_idx_q;
  logic [apr_pkg::HIST_W:0]    best_hist_q;
  logic [apr_pkg::FRAME_W-1:0] best_q;
  logic                        any_q;

  logic is_tick, is_victim, age_hit, better;

  assign is_tick    = (op_q == apr_pkg::OP_TICK);
  assign is_victim  = (op_q == apr_pkg::OP_VICTIM);
  assign count_next = {1'b0, count_q} + 17'd1;
  assign reach      = (count_next >= {1'b0, period_q});

  assign status_o.needs_scan = is_victim || (is_tick && enable_q && reach);
  assign status_o.scan_done  = pipe_vld_q && (p_idx_q == apr_pkg::LAST_FRAME);

  // frame under processing, registered alongside its history read
  assign age_hit = pipe_vld_q && is_tick && valid_q[p_idx_q] && evict_q[p_idx_q];
  assign better  = pipe_vld_q && is_victim && evict_q[p_idx_q]
                   && ({1'b0, rdata_q} < best_hist_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= operation_i;
      frame_q <= frame_i;
      sw_q    <= swappable_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= apr_pkg::PERIOD_RST;
      enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        apr_pkg::CFG_PERIOD: period_q <= cfg_wdata_i;
        apr_pkg::CFG_ENABLE: enable_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec && is_tick) begin
      if (reach) begin
        // disabled: hold at the period until an enabled tick ages
        count_q <= enable_q ? '0 : period_q;
      end else begin
        count_q <= count_next[apr_pkg::PERIOD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      evict_q <= '0;
      ref_q   <= '0;
    end else begin
      if (cmd_i.exec) begin
        unique case (op_q)
          apr_pkg::OP_REGISTER: begin
            if (enable_q) begin
              valid_q[frame_q] <= 1'b1;
              evict_q[frame_q] <= sw_q;
              ref_q[frame_q]   <= 1'b0;
            end
          end
          apr_pkg::OP_UNREGISTER: begin
            if (enable_q) begin
              valid_q[frame_q] <= 1'b0;
              evict_q[frame_q] <= 1'b0;
              ref_q[frame_q]   <= 1'b0;
            end
          end
          apr_pkg::OP_ACCESS: begin
            if (valid_q[frame_q]) ref_q[frame_q] <= 1'b1;
          end
          default: ;
        endcase
      end
      if (age_hit) ref_q[p_idx_q] <= 1'b0;
      if (cmd_i.finish && is_victim && any_q) evict_q[best_q] <= 1'b0;
    end
  end

  // history of a frame is only used while the frame is valid, so it needs no reset
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = frame_q;
    mem_wdata = apr_pkg::HIST_NEW;
    if (cmd_i.exec && (op_q == apr_pkg::OP_REGISTER) && enable_q) begin
      mem_we = 1'b1;
    end else if (age_hit) begin
      mem_we    = 1'b1;
      mem_waddr = p_idx_q;
      mem_wdata = {ref_q[p_idx_q], rdata_q[apr_pkg::HIST_W-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) hist_mem[mem_waddr] <= mem_wdata;
    rdata_q <= hist_mem[cnt_q[apr_pkg::FRAME_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pipe_vld_q  <= 1'b0;
      p_idx_q     <= '0;
      best_hist_q <= apr_pkg::BEST_INIT;
      best_q      <= '0;
      any_q       <= 1'b0;
    end else if (cmd_i.scan_start) begin
      cnt_q       <= '0;
      pipe_vld_q  <= 1'b0;
      best_hist_q <= apr_pkg::BEST_INIT;
      best_q      <= '0;
      any_q       <= 1'b0;
    end else if (cmd_i.scan) begin
      if (cnt_q < apr_pkg::CNT_W'(apr_pkg::FRAMES)) begin
        cnt_q      <= cnt_q + 7'd1;
        pipe_vld_q <= 1'b1;
        p_idx_q    <= cnt_q[apr_pkg::FRAME_W-1:0];
      end else begin
        pipe_vld_q <= 1'b0;
      end
      if (better) begin
        best_hist_q <= {1'b0, rdata_q};
        best_q      <= p_idx_q;
        any_q       <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= (cmd_i.exec && !status_o.needs_scan) || cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      victim_found_o <= is_victim && any_q;
      victim_frame_o <= (is_victim && any_q) ? best_q : '0;
      aged_o         <= is_tick;
    end else if (cmd_i.exec) begin
      victim_found_o <= 1'b0;
      victim_frame_o <= '0;
      aged_o         <= 1'b0;
    end
  end

  `APR_NEVER(a_evict_needs_valid, |(evict_q & ~valid_q))
  `APR_ASSERT(a_scan_end_count, status_o.scan_done |-> (cnt_q == apr_pkg::CNT_W'(apr_pkg::FRAMES)))
  `APR_ASSERT(a_victim_taken, (cmd_i.finish && is_victim && any_q) |=> !evict_q[$past(best_q)])

endmodule

`default_nettype wire

/* sv/aging_page_replacement.sv */
// register, unregister, access, idle ticks and unknown codes strobe a result once start
// is taken, through the exec state and the result register; busy is high for one cycle and
// no new word is taken while busy; victim picks and aging ticks sweep the 64-entry history
// memory one frame per cycle via its single read port, then finish and strobe the result
// results cannot be stalled; reset clears all frames, the tick count and the controller
// top level: joins apr_ctrl and apr_dp; depends on apr_pkg
`timescale 1ns / 1ps
`default_nettype none

module aging_page_replacement (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [apr_pkg::OP_W-1:0]      operation_i,
  input  wire logic [apr_pkg::FRAME_W-1:0]   frame_i,
  input  wire logic                          swappable_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [apr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [apr_pkg::CFG_W-1:0]     cfg_wdata_i,
  output logic                               result_valid_o,
  output logic                               victim_found_o,
  output logic [apr_pkg::FRAME_W-1:0]        victim_frame_o,
  output logic                               aged_o
);

  apr_pkg::cmd_t    cmd;
  apr_pkg::status_t status;

  apr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  apr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .operation_i    (operation_i),
    .frame_i        (frame_i),
    .swappable_i    (swappable_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .victim_found_o (victim_found_o),
    .victim_frame_o (victim_frame_o),
    .aged_o         (aged_o)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_aging_page_replacement.sv */
// self-checking testbench for aging_page_replacement: directed words, then random phases
// over several period and enable settings, checked against a frame-age predictor class
// depends on apr_pkg and the aging_page_replacement top level
`timescale 1ns / 1ps

module tb_aging_page_replacement;

  localparam int CLK_PERIOD     = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 80;

  typedef struct packed {
    logic                        found;
    logic [apr_pkg::FRAME_W-1:0] frame;
    logic                        aged;
  } page_result_t;

  // mirrors the frame table and tick counter, queues the result each word should produce
  class frame_age_tracker;
    logic [apr_pkg::HIST_W-1:0]   history [apr_pkg::FRAMES];
    logic                         in_use [apr_pkg::FRAMES];
    logic                         evictable [apr_pkg::FRAMES];
    logic                         referenced [apr_pkg::FRAMES];
    logic [apr_pkg::PERIOD_W-1:0] tick_cnt;
    logic [apr_pkg::PERIOD_W-1:0] period;
    logic                         enabled;
    page_result_t                 pending_results [$];
    int                           mismatches;

    function new();
      foreach (history[i]) begin
        history[i]    = '0;
        in_use[i]     = 1'b0;
        evictable[i]  = 1'b0;
        referenced[i] = 1'b0;
      end
      tick_cnt   = '0;
      period     = apr_pkg::PERIOD_RST;
      enabled    = 1'b1;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void write_reg(logic [apr_pkg::CFG_IDX_W-1:0] idx,
                            logic [apr_pkg::CFG_W-1:0] data);
      case (idx)
        apr_pkg::CFG_PERIOD: period = data[apr_pkg::PERIOD_W-1:0];
        apr_pkg::CFG_ENABLE: enabled = data[0];
        default: ;
      endcase
    endfunction

    function void apply_word(logic [apr_pkg::OP_W-1:0] op, logic [apr_pkg::FRAME_W-1:0] fr,
                             logic sw);
      page_result_t               res;
      logic [apr_pkg::PERIOD_W:0] next_cnt;
      int                         best;
      int                         best_hist;
      res = '0;
      case (op)
        apr_pkg::OP_TICK: begin
          next_cnt = {1'b0, tick_cnt} + 1'b1;
          // a count at or past the period fires, so period 0 behaves like 1
          if (next_cnt >= {1'b0, period}) begin
            if (enabled) begin
              tick_cnt = '0;
              res.aged = 1'b1;
              for (int i = 0; i < apr_pkg::FRAMES; i++) begin
                if (in_use[i] && evictable[i]) begin
                  history[i]    = {referenced[i], history[i][apr_pkg::HIST_W-1:1]};
                  referenced[i] = 1'b0;
                end
              end
            end else begin
              // disabled: hold at the period until the next enabled tick
              tick_cnt = period;
            end
          end else begin
            tick_cnt = next_cnt[apr_pkg::PERIOD_W-1:0];
          end
        end
        apr_pkg::OP_REGISTER: begin
          if (enabled) begin
            in_use[fr]     = 1'b1;
            history[fr]    = apr_pkg::HIST_NEW;
            evictable[fr]  = sw;
            referenced[fr] = 1'b0;
          end
        end
        apr_pkg::OP_UNREGISTER: begin
          if (enabled) begin
            in_use[fr]     = 1'b0;
            history[fr]    = '0;
            evictable[fr]  = 1'b0;
            referenced[fr] = 1'b0;
          end
        end
        apr_pkg::OP_ACCESS: begin
          if (in_use[fr]) referenced[fr] = 1'b1;
        end
        apr_pkg::OP_VICTIM: begin
          best      = -1;
          best_hist = int'(apr_pkg::HIST_MAX) + 1;
          for (int i = 0; i < apr_pkg::FRAMES; i++) begin
            if (evictable[i] && int'(history[i]) < best_hist) begin
              best      = i;
              best_hist = int'(history[i]);
            end
          end
          if (best >= 0) begin
            evictable[best] = 1'b0;
            res.found       = 1'b1;
            res.frame       = apr_pkg::FRAME_W'(best);
          end
        end
        default: ;
      endcase
      pending_results.push_back(res);
    endfunction

    function void check_result(logic found, logic [apr_pkg::FRAME_W-1:0] fr, logic aged);
      page_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: found=%0d frame=%0d aged=%0d", found, fr, aged);
        return;
      end
      want = pending_results.pop_front();
      if (want.found !== found || want.frame !== fr || want.aged !== aged) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch at %0t: expected found=%0d frame=%0d aged=%0d, ",
                    "got found=%0d frame=%0d aged=%0d"},
                   $realtime, want.found, want.frame, want.aged, found, fr, aged);
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  logic [apr_pkg::OP_W-1:0]      operation;
  logic [apr_pkg::FRAME_W-1:0]   frame;
  logic                          swappable;
  logic                          cfg_we;
  logic [apr_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [apr_pkg::CFG_W-1:0]     cfg_wdata;
  logic                          result_valid;
  logic                          victim_found;
  logic [apr_pkg::FRAME_W-1:0]   victim_frame;
  logic                          aged;

  frame_age_tracker tracker;
  int quiet_cycles = 0;

  aging_page_replacement dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation),
    .frame_i        (frame),
    .swappable_i    (swappable),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .result_valid_o (result_valid),
    .victim_found_o (victim_found),
    .victim_frame_o (victim_frame),
    .aged_o         (aged)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // sample at the rising edge: results first, then register writes, then taken words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid) tracker.check_result(victim_found, victim_frame, aged);
      if (cfg_we) tracker.write_reg(cfg_idx, cfg_wdata);
      if (start && !busy) tracker.apply_word(operation, frame, swappable);
      if (result_valid || cfg_we || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("tb_aging_page_replacement failed");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(input logic [apr_pkg::OP_W-1:0] op,
                           input logic [apr_pkg::FRAME_W-1:0] fr, input logic sw);
    operation <= op;
    frame     <= fr;
    swappable <= sw;
    start     <= 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic idle_gap(input bit burst);
    int r;
    int n;
    n = 0;
    if (!burst) begin
      r = $urandom_range(9);
      if (r >= 9) n = $urandom_range(40, 10);
      else if (r >= 6) n = $urandom_range(3, 1);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // register writes only once every pending word has come back
  task automatic write_reg(input logic [apr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [apr_pkg::CFG_W-1:0] data);
    start <= 1'b0;
    while (tracker.pending() != 0 || busy) @(negedge clk_i);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic word_gap(input logic [apr_pkg::OP_W-1:0] op,
                          input logic [apr_pkg::FRAME_W-1:0] fr, input logic sw);
    send_word(op, fr, sw);
    idle_gap(1'b0);
  endtask

  task automatic random_phase(input int per, input bit en, input int words);
    logic [apr_pkg::OP_W-1:0]    op;
    logic [apr_pkg::FRAME_W-1:0] fr;
    logic                        sw;
    bit                          burst;
    int                          r;
    int                          counted;
    write_reg(apr_pkg::CFG_PERIOD, apr_pkg::CFG_W'(per));
    write_reg(apr_pkg::CFG_ENABLE, apr_pkg::CFG_W'(en));
    burst   = ($urandom_range(3) == 0);
    counted = 0;
    while (counted < words) begin
      r = $urandom_range(99);
      if (r < 24) op = apr_pkg::OP_REGISTER;
      else if (r < 50) op = apr_pkg::OP_ACCESS;
      else if (r < 70) op = apr_pkg::OP_TICK;
      else if (r < 84) op = apr_pkg::OP_VICTIM;
      else if (r < 93) op = apr_pkg::OP_UNREGISTER;
      else op = apr_pkg::OP_W'($urandom_range(7, 5));
      // crowd a low group of frames so ties and reuse are common
      fr = ($urandom_range(9) < 7) ? apr_pkg::FRAME_W'($urandom_range(15))
                                   : apr_pkg::FRAME_W'($urandom);
      sw = ($urandom_range(4) != 0);
      send_word(op, fr, sw);
      if (op == apr_pkg::OP_TICK || op == apr_pkg::OP_VICTIM || op == apr_pkg::OP_ACCESS ||
          (en && (op == apr_pkg::OP_REGISTER || op == apr_pkg::OP_UNREGISTER)))
        counted++;
      if (!burst && $urandom_range(19) == 0) burst = 1'b1;
      else if (burst && $urandom_range(29) == 0) burst = 1'b0;
      idle_gap(burst);
    end
  endtask

  initial begin
    int periods [8];
    int enables [8];
    int words [8];
    periods = '{1, 3, 7, 2, 65535, 5, 1, 12};
    enables = '{1, 1, 0, 1, 1, 1, 0, 1};
    words   = '{90, 90, 45, 90, 90, 90, 40, 90};
    tracker   = new();
    rst_ni    = 1'b0;
    start     = 1'b0;
    operation = '0;
    frame     = '0;
    swappable = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty pick, registration, accesses, picks, unknown codes, unregister, ticks
    word_gap(apr_pkg::OP_VICTIM, '0, 1'b0);
    word_gap(apr_pkg::OP_REGISTER, '0, 1'b1);
    word_gap(apr_pkg::OP_REGISTER, apr_pkg::LAST_FRAME, 1'b1);
    word_gap(apr_pkg::OP_REGISTER, 6'd5, 1'b0);
    word_gap(apr_pkg::OP_REGISTER, 6'd42, 1'b1);
    word_gap(apr_pkg::OP_ACCESS, apr_pkg::LAST_FRAME, 1'b0);
    word_gap(apr_pkg::OP_ACCESS, 6'd10, 1'b1);
    word_gap(apr_pkg::OP_ACCESS, 6'd5, 1'b0);
    word_gap(apr_pkg::OP_VICTIM, 6'd33, 1'b1);
    word_gap(apr_pkg::OP_VICTIM, '0, 1'b0);
    word_gap(3'd5, 6'd21, 1'b1);
    word_gap(3'd6, 6'd42, 1'b0);
    word_gap(3'd7, apr_pkg::LAST_FRAME, 1'b1);
    word_gap(apr_pkg::OP_UNREGISTER, 6'd42, 1'b0);
    word_gap(apr_pkg::OP_TICK, '0, 1'b0);
    word_gap(apr_pkg::OP_TICK, apr_pkg::LAST_FRAME, 1'b1);
    word_gap(apr_pkg::OP_TICK, '0, 1'b0);
    // period dropped below the running count
    write_reg(apr_pkg::CFG_PERIOD, 16'd2);
    word_gap(apr_pkg::OP_TICK, '0, 1'b0);
    word_gap(apr_pkg::OP_TICK, '0, 1'b0);
    // disabled: register and unregister ignored, count held, picks still work
    write_reg(apr_pkg::CFG_ENABLE, 16'd0);
    word_gap(apr_pkg::OP_REGISTER, 6'd7, 1'b1);
    word_gap(apr_pkg::OP_UNREGISTER, apr_pkg::LAST_FRAME, 1'b0);
    word_gap(apr_pkg::OP_TICK, '0, 1'b0);
    word_gap(apr_pkg::OP_TICK, '0, 1'b0);
    word_gap(apr_pkg::OP_VICTIM, '0, 1'b0);
    write_reg(apr_pkg::CFG_ENABLE, 16'd1);
    word_gap(apr_pkg::OP_TICK, '0, 1'b0);
    write_reg(apr_pkg::CFG_PERIOD, 16'd0);
    word_gap(apr_pkg::OP_TICK, '0, 1'b0);

    foreach (periods[p]) random_phase(periods[p], enables[p][0], words[p]);

    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("tb_aging_page_replacement passed");
    end else begin
      $display("tb_aging_page_replacement failed");
    end
    $finish;
  end

endmodule
